[hdl/histeq_pkg.sv]
// Shared constants and controller/datapath interface types for the histogram equalizer.
`timescale 1ns / 1ps
`default_nettype none
package histeq_pkg;

  localparam int LEVELS     = 256;
  localparam int LVL_W      = 8;
  localparam int CNT_W      = 21;
  localparam int NUM_W      = CNT_W + LVL_W;
  localparam int BIT_W      = 3;
  localparam logic [CNT_W-1:0] MAX_PIXELS = 21'd1048576;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_MAP  = 1'b1;

  typedef struct packed {
    logic load_rd;
    logic load_wr;
    logic map_rd;
    logic build_start;
    logic build_rd;
    logic acc;
    logic div_init;
    logic div_step;
    logic map_wr;
    logic build_done;
  } he_cmd_t;

  typedef struct packed {
    logic div_last;
    logic idx_last;
  } he_sts_t;

endpackage
`default_nettype wire

[hdl/histeq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module histeq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[hdl/histeq_datapath.sv]
// Datapath: bin and table memories, pixel total, cumulative sum and bit-serial divider.
`timescale 1ns / 1ps
`default_nettype none
module histeq_datapath
  import histeq_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire he_cmd_t          cmd,
  output he_sts_t               sts,
  input  wire logic [LVL_W-1:0] in_pixel,
  input  wire logic             in_last,
  output logic                  out_valid,
  output logic      [LVL_W-1:0] out_mapped_pixel,
  output logic                  out_last_out
);

  logic [LVL_W-1:0]  pix_r;
  logic [CNT_W-1:0]  total_r;
  logic [CNT_W-1:0]  cum_r;
  logic [NUM_W-1:0]  rem_r;
  logic [NUM_W-1:0]  rem_nxt;
  logic [LVL_W-1:0]  quo_r;
  logic [LVL_W-1:0]  quo_nxt;
  logic [BIT_W-1:0]  bit_r;
  logic [LVL_W-1:0]  idx_r;
  logic [LEVELS-1:0] bin_vld_r;
  logic              bin_hit_r;
  logic              built_r;
  logic              out_vld_r;
  logic              out_last_r;

  logic [CNT_W-1:0]  bin_rdata;
  logic [CNT_W-1:0]  bin_val;
  logic [LVL_W-1:0]  bin_raddr;
  logic              bin_re;
  logic              bin_we;
  logic              cnt_ok;
  logic [LVL_W-1:0]  map_rdata;
  logic [LVL_W-1:0]  map_wdata;
  logic [NUM_W-1:0]  dsh;
  logic              ge;

  // Entries never written since the last clear read as zero.
  assign bin_val   = bin_hit_r ? bin_rdata : '0;
  assign cnt_ok    = total_r < MAX_PIXELS;
  assign bin_re    = cmd.load_rd | cmd.build_rd;
  assign bin_raddr = cmd.build_rd ? idx_r : in_pixel;
  assign bin_we    = cmd.load_wr & cnt_ok;
  assign map_wdata = (total_r == '0) ? '0 : quo_r;

  // Restoring division of 255*cum by the total, one quotient bit per cycle.
  assign dsh     = NUM_W'(total_r) << bit_r;
  assign ge      = rem_r >= dsh;
  assign rem_nxt = ge ? (rem_r - dsh) : rem_r;
  assign quo_nxt = quo_r | (ge ? (LVL_W'(1) << bit_r) : '0);

  histeq_ram #(.WIDTH(CNT_W), .DEPTH(LEVELS)) u_bin_ram (
    .clk   (clk),
    .we    (bin_we),
    .waddr (pix_r),
    .wdata (bin_val + CNT_W'(1)),
    .re    (bin_re),
    .raddr (bin_raddr),
    .rdata (bin_rdata)
  );

  histeq_ram #(.WIDTH(LVL_W), .DEPTH(LEVELS)) u_map_ram (
    .clk   (clk),
    .we    (cmd.map_wr),
    .waddr (idx_r),
    .wdata (map_wdata),
    .re    (cmd.map_rd),
    .raddr (in_pixel),
    .rdata (map_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r   <= '0;
      bin_vld_r <= '0;
      built_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= cmd.map_rd;
      if (bin_we) begin
        total_r          <= total_r + CNT_W'(1);
        bin_vld_r[pix_r] <= 1'b1;
      end
      if (cmd.build_done) begin
        total_r   <= '0;
        bin_vld_r <= '0;
        built_r   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_rd) begin
      pix_r <= in_pixel;
    end
    if (bin_re) begin
      bin_hit_r <= bin_vld_r[bin_raddr];
    end
    if (cmd.map_rd) begin
      out_last_r <= in_last;
    end
    if (cmd.build_start) begin
      idx_r <= '0;
      cum_r <= '0;
    end
    if (cmd.acc) begin
      cum_r <= cum_r + bin_val;
    end
    if (cmd.div_init) begin
      rem_r <= {cum_r, LVL_W'(0)} - NUM_W'(cum_r);
      quo_r <= '0;
      bit_r <= BIT_W'(LVL_W - 1);
    end
    if (cmd.div_step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      bit_r <= bit_r - BIT_W'(1);
    end
    if (cmd.map_wr) begin
      idx_r <= idx_r + LVL_W'(1);
    end
  end

  assign sts.div_last = (bit_r == '0);
  assign sts.idx_last = (idx_r == LVL_W'(LEVELS - 1));

  assign out_valid        = out_vld_r;
  assign out_mapped_pixel = built_r ? map_rdata : '0;
  assign out_last_out     = out_last_r;

endmodule
`default_nettype wire

[hdl/histeq_ctrl.sv]
// Controller: sequences pixel loads, map lookups and the per-level table build.
`timescale 1ns / 1ps
`default_nettype none
module histeq_ctrl
  import histeq_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  input  wire logic    in_kind,
  input  wire logic    in_last,
  input  wire he_sts_t sts,
  output logic         busy,
  output he_cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD_WR,
    S_BUILD_RD,
    S_BUILD_ACC,
    S_DIV_INIT,
    S_DIV,
    S_MAP_WR
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   busy_r;
  logic   last_r;
  logic   last_nxt;

  always_comb begin
    state_nxt = state_r;
    last_nxt  = last_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_kind == KIND_MAP) begin
            cmd.map_rd = 1'b1;
          end else begin
            cmd.load_rd = 1'b1;
            last_nxt    = in_last;
            state_nxt   = S_LOAD_WR;
          end
        end
      end
      S_LOAD_WR: begin
        cmd.load_wr = 1'b1;
        if (last_r) begin
          cmd.build_start = 1'b1;
          state_nxt       = S_BUILD_RD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_BUILD_RD: begin
        cmd.build_rd = 1'b1;
        state_nxt    = S_BUILD_ACC;
      end
      S_BUILD_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_MAP_WR;
        end
      end
      S_MAP_WR: begin
        cmd.map_wr = 1'b1;
        if (sts.idx_last) begin
          cmd.build_done = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          state_nxt = S_BUILD_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
      last_r  <= last_nxt;
    end
  end

  assign busy = busy_r;

endmodule
`default_nettype wire

[hdl/histogram_equalizer_unit.sv]
// Top level: 8-bit histogram equalizer, controller plus datapath.
// Map beat: result strobed in the cycle after acceptance; a map beat can be taken every cycle while busy is low.
// Load beat: bin RAM read, then increment write; busy is high during the write.
// Last load beat: then builds the table level by level, paced by the bit-serial divider
// and the single bin RAM read port; busy throughout.
// Reset: bins and total clear at once through per-bin valid flags; table reads 0 until built.
`timescale 1ns / 1ps
`default_nettype none
module histogram_equalizer_unit
  import histeq_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic             in_kind,
  input  wire logic [LVL_W-1:0] in_pixel,
  input  wire logic             in_last,
  output logic                  out_valid,
  output logic      [LVL_W-1:0] out_mapped_pixel,
  output logic                  out_last_out
);

  he_cmd_t cmd;
  he_sts_t sts;

  histeq_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_kind (in_kind),
    .in_last (in_last),
    .sts     (sts),
    .busy    (busy),
    .cmd     (cmd)
  );

  histeq_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_pixel         (in_pixel),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_mapped_pixel (out_mapped_pixel),
    .out_last_out     (out_last_out)
  );

endmodule
`default_nettype wire

[hdl/histeq_checker.sv]
// Port-level checker for the histogram equalizer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module histeq_checker
  import histeq_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             start,
  input wire logic             busy,
  input wire logic             in_kind,
  input wire logic             in_last,
  input wire logic             out_valid,
  input wire logic [LVL_W-1:0] out_mapped_pixel,
  input wire logic             out_last_out
);

  logic map_acc;
  logic load_acc;

  assign map_acc  = start && !busy && (in_kind == KIND_MAP);
  assign load_acc = start && !busy && (in_kind == KIND_LOAD);

  a_map_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    map_acc |=> out_valid)
    else $error("map beat produced no result");

  a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(map_acc))
    else $error("result without a preceding map beat");

  a_last_follows: assert property (@(posedge clk) disable iff (!rst_n)
    map_acc |=> (out_last_out == $past(in_last)))
    else $error("last flag not carried to result");

  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    load_acc |=> (busy && !out_valid))
    else $error("load beat did not hold off the next beat");

  a_result_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown({out_mapped_pixel, out_last_out}))
    else $error("result beat carries unknown bits");

endmodule

bind histogram_equalizer_unit histeq_checker u_histeq_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_kind          (in_kind),
  .in_last          (in_last),
  .out_valid        (out_valid),
  .out_mapped_pixel (out_mapped_pixel),
  .out_last_out     (out_last_out)
);
`default_nettype wire

[bench/histeq_map_checker.sv]
// Checker for the histogram equalizer: tracks bins and table, compares every map result beat.
`timescale 1ns / 1ps
module histeq_map_checker
  import histeq_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic             busy,
  input  wire logic             in_kind,
  input  wire logic [LVL_W-1:0] in_pixel,
  input  wire logic             in_last,
  input  wire logic             out_valid,
  input  wire logic [LVL_W-1:0] out_mapped_pixel,
  input  wire logic             out_last_out,
  output int                    mismatch_count,
  output int                    open_count
);

  localparam longint unsigned PEAK_LEVEL = 255;

  typedef struct packed {
    logic [LVL_W-1:0] level;
    logic             last;
  } map_beat_t;

  logic [CNT_W-1:0] bin_count [LEVELS];
  logic [CNT_W-1:0] image_total;
  logic [LVL_W-1:0] level_table [LEVELS];
  map_beat_t        awaited_beats [$];

  // Cumulative table, floor(255 * running / total), then the histogram starts over.
  function automatic void rebuild_table();
    longint unsigned running;
    running = 0;
    for (int i = 0; i < LEVELS; i++) begin
      running += 64'(bin_count[i]);
      if (image_total == '0) begin
        level_table[i] = '0;
      end else begin
        level_table[i] = LVL_W'((PEAK_LEVEL * running) / 64'(image_total));
      end
    end
    foreach (bin_count[i]) bin_count[i] = '0;
    image_total = '0;
  endfunction

  always @(posedge clk) begin : watch
    map_beat_t seen;
    map_beat_t wanted;
    if (!rst_n) begin
      foreach (bin_count[i]) bin_count[i] = '0;
      foreach (level_table[i]) level_table[i] = '0;
      image_total = '0;
      awaited_beats.delete();
      mismatch_count = 0;
    end else begin
      // result beats first: a map result never shows up in its own accept cycle
      if (out_valid !== 1'b0) begin
        seen.level = out_mapped_pixel;
        seen.last  = out_last_out;
        if (awaited_beats.size() == 0) begin
          $display("%0t: unexpected result beat: expected none, got level %0d last %0b",
                   $time, seen.level, seen.last);
          mismatch_count++;
        end else begin
          wanted = awaited_beats.pop_front();
          if (seen.level !== wanted.level) begin
            $display("%0t: mapped_pixel: expected %0d, got %0d",
                     $time, wanted.level, seen.level);
            mismatch_count++;
          end
          if (seen.last !== wanted.last) begin
            $display("%0t: last_out: expected %0b, got %0b", $time, wanted.last, seen.last);
            mismatch_count++;
          end
        end
      end
      if (start && !busy) begin
        if (in_kind == KIND_MAP) begin
          wanted.level = level_table[in_pixel];
          wanted.last  = in_last;
          awaited_beats.push_back(wanted);
        end else begin
          // a full image drops further pixels, but their last flag still closes it
          if (image_total < MAX_PIXELS) begin
            bin_count[in_pixel]++;
            image_total++;
          end
          if (in_last) rebuild_table();
        end
      end
    end
    open_count = awaited_beats.size();
  end

endmodule

[bench/histogram_equalizer_unit_tb.sv]
// Testbench top for histogram_equalizer_unit: stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module histogram_equalizer_unit_tb;
  import histeq_pkg::*;

  localparam int WATCHDOG_LIMIT = 16384;
  localparam int RANDOM_ITEMS   = 1600;
  localparam int CALM_ITEMS     = 200;
  localparam int DRAIN_CYCLES   = 16;

  typedef enum int {SPREAD_UNIFORM, SPREAD_WINDOW, SPREAD_PAIR, SPREAD_FLAT} spread_t;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic             in_kind;
  logic [LVL_W-1:0] in_pixel;
  logic             in_last;
  logic             out_valid;
  logic [LVL_W-1:0] out_mapped_pixel;
  logic             out_last_out;
  int               mismatch_count;
  int               open_count;
  int               stall_cycles = 0;
  int               beats_sent;
  int               gap_odds;

  histogram_equalizer_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_kind          (in_kind),
    .in_pixel         (in_pixel),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_mapped_pixel (out_mapped_pixel),
    .out_last_out     (out_last_out)
  );

  histeq_map_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_kind          (in_kind),
    .in_pixel         (in_pixel),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_mapped_pixel (out_mapped_pixel),
    .out_last_out     (out_last_out),
    .mismatch_count   (mismatch_count),
    .open_count       (open_count)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("histogram_equalizer_unit_tb: done, errors");
      $finish;
    end
  end

  task automatic send_beat(input logic kind, input logic [LVL_W-1:0] pixel, input logic last);
    @(negedge clk);
    start    = 1'b1;
    in_kind  = kind;
    in_pixel = pixel;
    in_last  = last;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    beats_sent++;
  endtask

  task automatic hold_off(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start    = 1'b0;
      in_kind  = 1'($urandom);
      in_pixel = LVL_W'($urandom);
      in_last  = 1'($urandom);
    end
  endtask

  task automatic maybe_hold_off();
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) hold_off($urandom_range(1, 8));
  endtask

  function automatic logic [LVL_W-1:0] pick_level(input spread_t spread,
                                                  input logic [LVL_W-1:0] base,
                                                  input logic [LVL_W-1:0] span);
    case (spread)
      SPREAD_UNIFORM: return LVL_W'($urandom_range(0, 255));
      SPREAD_WINDOW:  return base + LVL_W'($urandom_range(0, span));
      SPREAD_PAIR:    return ($urandom_range(0, 1) != 0) ? base : base + span;
      default:        return base;
    endcase
  endfunction

  task automatic send_maps(input int count);
    for (int j = 0; j < count; j++) begin
      maybe_hold_off();
      send_beat(KIND_MAP, LVL_W'($urandom_range(0, 255)),
                (j == count - 1) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 9) == 0));
    end
  endtask

  // One image with a random spread of levels, then a burst of maps over it.
  task automatic random_image();
    spread_t          spread;
    logic [LVL_W-1:0] base;
    logic [LVL_W-1:0] span;
    int               loads;
    spread = spread_t'($urandom_range(0, 3));
    base   = LVL_W'($urandom_range(0, 255));
    span   = LVL_W'($urandom_range(0, 255 - base));
    loads  = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 24);
    for (int i = 0; i < loads; i++) begin
      maybe_hold_off();
      // map beat mid-image still reads the previous table
      if ($urandom_range(0, 11) == 0) begin
        send_beat(KIND_MAP, LVL_W'($urandom_range(0, 255)), 1'($urandom));
      end
      send_beat(KIND_LOAD, pick_level(spread, base, span), i == loads - 1);
    end
    send_maps($urandom_range(1, 30));
  endtask

  initial begin
    int random_base;
    rst_n      = 1'b0;
    start      = 1'b0;
    in_kind    = KIND_LOAD;
    in_pixel   = '0;
    in_last    = 1'b0;
    gap_odds   = 0;
    beats_sent = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // no table built yet: everything maps to zero
    send_beat(KIND_MAP, 8'd0, 1'b0);
    send_beat(KIND_MAP, 8'd255, 1'b1);
    send_beat(KIND_MAP, 8'd128, 1'b0);
    // small image over the extremes
    send_beat(KIND_LOAD, 8'd0, 1'b0);
    send_beat(KIND_LOAD, 8'd255, 1'b0);
    send_beat(KIND_LOAD, 8'd255, 1'b0);
    send_beat(KIND_LOAD, 8'd128, 1'b1);
    send_beat(KIND_MAP, 8'd0, 1'b0);
    send_beat(KIND_MAP, 8'd127, 1'b1);
    send_beat(KIND_MAP, 8'd128, 1'b0);
    send_beat(KIND_MAP, 8'd254, 1'b0);
    send_beat(KIND_MAP, 8'd255, 1'b1);
    // single-pixel images at each end
    send_beat(KIND_LOAD, 8'd255, 1'b1);
    send_beat(KIND_MAP, 8'd254, 1'b0);
    send_beat(KIND_MAP, 8'd255, 1'b1);
    send_beat(KIND_LOAD, 8'd0, 1'b1);
    send_beat(KIND_MAP, 8'd0, 1'b1);
    send_beat(KIND_MAP, 8'd255, 1'b0);

    // two-pixel image, one at each end
    send_beat(KIND_LOAD, 8'd255, 1'b0);
    send_beat(KIND_LOAD, 8'd0, 1'b1);
    send_beat(KIND_MAP, 8'd0, 1'b0);
    send_beat(KIND_MAP, 8'd254, 1'b0);
    send_beat(KIND_MAP, 8'd255, 1'b1);
    send_maps(8);

    random_base = beats_sent;
    while (beats_sent - random_base < RANDOM_ITEMS) begin
      if (beats_sent - random_base < RANDOM_ITEMS - CALM_ITEMS) begin
        case ($urandom_range(0, 2))
          0:       gap_odds = 0;
          1:       gap_odds = 2;
          default: gap_odds = 6;
        endcase
      end else begin
        gap_odds = 0;
      end
      case ($urandom_range(0, 9))
        0: send_maps($urandom_range(1, 12));
        1: begin
          maybe_hold_off();
          send_beat(KIND_LOAD, LVL_W'($urandom_range(0, 255)), 1'b1);
        end
        default: random_image();
      endcase
    end

    @(negedge clk);
    start = 1'b0;
    while (open_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("histogram_equalizer_unit_tb: done, clean");
    end else begin
      $display("histogram_equalizer_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/histeq_pkg.sv
hdl/histeq_ram.sv
hdl/histeq_datapath.sv
hdl/histeq_ctrl.sv
hdl/histogram_equalizer_unit.sv
hdl/histeq_checker.sv
bench/histeq_map_checker.sv
bench/histogram_equalizer_unit_tb.sv
